// File: hdl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes for the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  // request codes
  localparam logic [1:0] REQ_CREATE   = 2'd0;
  localparam logic [1:0] REQ_TICK     = 2'd1;
  localparam logic [1:0] REQ_DISPATCH = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_TASK   = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;

  // one slot entry in the table memory
  typedef struct packed {
    logic [15:0] period;
    logic [15:0] counter;
  } slot_entry_t;

  // one result item on its way to the output register
  typedef struct packed {
    logic [1:0] kind;
    logic       err;
    logic [2:0] idx;
    logic       last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_NONE,
    S_TICK,
    S_DISP
  } state_t;

endpackage

// File: hdl/pts_ram.sv
// ----------------------------------------------------------------------------
// pts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/pts_rsp.sv
// ----------------------------------------------------------------------------
// pts_rsp
// Output register for result items; frees up as the receiver takes an item.
// ----------------------------------------------------------------------------
module pts_rsp (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pts_pkg::rsp_t push_data,
  output logic          free,
  input  logic          rsp_stall,
  output logic          rsp_valid,
  output logic [1:0]    result_kind,
  output logic          error_flag,
  output logic [2:0]    task_index,
  output logic          last
);
  import pts_pkg::*;

  rsp_t data;

  assign free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (push) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      data <= push_data;
    end
  end

  assign result_kind = data.kind;
  assign error_flag  = data.err;
  assign task_index  = data.idx;
  assign last        = data.last;

endmodule

// File: hdl/pts_seq.sv
// ----------------------------------------------------------------------------
// pts_seq
// Request sequencer: slot flags, table read-modify-write walk for ticks and
// in-order slot scan for dispatch.
// ----------------------------------------------------------------------------
module pts_seq #(
  parameter int TASK_SLOTS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [1:0]                  req_type,
  input  logic [3:0]                  task_slot,
  input  logic [15:0]                 initial_delay,
  input  logic [15:0]                 period,
  input  logic                        has_task,
  input  logic                        rsp_free,
  output logic                        push,
  output pts_pkg::rsp_t               push_data,
  output logic                        ram_we,
  output logic [((TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1)-1:0] ram_waddr,
  output pts_pkg::slot_entry_t        ram_wdata,
  output logic [((TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1)-1:0] ram_raddr,
  input  pts_pkg::slot_entry_t        ram_rdata
);
  import pts_pkg::*;

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TASK_SLOTS + 1);

  state_t                 state, state_next;
  logic [CNT_W-1:0]       idx, idx_next;
  logic                   wb_vld, wb_vld_next;
  logic [SLOT_W-1:0]      wb_idx, wb_idx_next;
  logic [TASK_SLOTS-1:0]  valid_bits, valid_bits_next;
  logic [TASK_SLOTS-1:0]  ready_bits, ready_bits_next;
  logic                   create_err, create_err_next;

  logic                   accept;
  logic                   in_range;
  logic                   create_ok;
  logic [TASK_SLOTS-1:0]  pending;
  logic [SLOT_W-1:0]      cur;
  logic [3:0]             cur_ext;
  logic                   idx_live;
  logic                   higher_pending;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign in_range  = ({1'b0, task_slot} < 5'(TASK_SLOTS));
  assign create_ok = in_range && has_task;
  assign pending   = valid_bits & ready_bits;
  assign cur       = idx[SLOT_W-1:0];
  assign cur_ext   = 4'(cur);
  assign idx_live  = (idx < CNT_W'(TASK_SLOTS));
  assign ram_raddr = idx_live ? cur : '0;

  // any ready slot above the one under scan
  always_comb begin
    higher_pending = 1'b0;
    for (int j = 0; j < TASK_SLOTS; j++) begin
      if (j > int'(cur) && pending[j]) begin
        higher_pending = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      wb_vld     <= 1'b0;
      valid_bits <= '0;
      ready_bits <= '0;
    end else begin
      state      <= state_next;
      idx        <= idx_next;
      wb_vld     <= wb_vld_next;
      valid_bits <= valid_bits_next;
      ready_bits <= ready_bits_next;
    end
  end

  always_ff @(posedge clk) begin
    wb_idx     <= wb_idx_next;
    create_err <= create_err_next;
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    wb_vld_next     = 1'b0;
    wb_idx_next     = wb_idx;
    valid_bits_next = valid_bits;
    ready_bits_next = ready_bits;
    create_err_next = create_err;
    push            = 1'b0;
    push_data       = '0;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_CREATE: begin
              create_err_next = !create_ok;
              state_next      = S_CREATE;
              if (create_ok) begin
                ram_we            = 1'b1;
                ram_waddr         = task_slot[SLOT_W-1:0];
                ram_wdata.period  = period;
                ram_wdata.counter = initial_delay;
                valid_bits_next[task_slot[SLOT_W-1:0]] = 1'b1;
                ready_bits_next[task_slot[SLOT_W-1:0]] = 1'b0;
              end
            end
            REQ_TICK: begin
              idx_next   = '0;
              state_next = S_TICK;
            end
            REQ_DISPATCH: begin
              idx_next   = '0;
              state_next = (|pending) ? S_DISP : S_NONE;
            end
            default: ;
          endcase
        end
      end

      S_CREATE: begin
        if (rsp_free) begin
          push           = 1'b1;
          push_data.kind = KIND_CREATE;
          push_data.err  = create_err;
          push_data.last = 1'b1;
          state_next     = S_IDLE;
        end
      end

      S_NONE: begin
        if (rsp_free) begin
          push           = 1'b1;
          push_data.kind = KIND_NONE;
          push_data.last = 1'b1;
          state_next     = S_IDLE;
        end
      end

      S_TICK: begin
        // read stage
        if (idx_live) begin
          wb_vld_next = 1'b1;
          wb_idx_next = cur;
          idx_next    = idx + CNT_W'(1);
        end
        // write-back stage, one slot behind the read
        if (wb_vld && valid_bits[wb_idx]) begin
          ram_we    = 1'b1;
          ram_waddr = wb_idx;
          if (ram_rdata.counter == 16'd0) begin
            ram_wdata.period  = ram_rdata.period;
            ram_wdata.counter = ram_rdata.period;
            ready_bits_next[wb_idx] = 1'b1;
          end else begin
            ram_wdata.period  = ram_rdata.period;
            ram_wdata.counter = ram_rdata.counter - 16'd1;
          end
        end
        if (!idx_live && !wb_vld) begin
          state_next = S_IDLE;
        end
      end

      S_DISP: begin
        if (pending[cur]) begin
          if (rsp_free) begin
            push           = 1'b1;
            push_data.kind = KIND_TASK;
            push_data.idx  = cur_ext[2:0];
            push_data.last = !higher_pending;
            ready_bits_next[cur] = 1'b0;
            if (higher_pending) begin
              idx_next = idx + CNT_W'(1);
            end else begin
              state_next = S_IDLE;
            end
          end
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> rsp_free)
    else $error("result pushed into a full output register");

  a_disp_drained: assert property (@(posedge clk) disable iff (rst)
    (push && push_data.kind == KIND_TASK && push_data.last) |=> (pending == '0))
    else $error("ready slots left after final dispatched item");

  a_none_empty: assert property (@(posedge clk) disable iff (rst)
    (push && push_data.kind == KIND_NONE) |-> (pending == '0))
    else $error("no-task result while a slot is ready");

  a_tick_valid_wr: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == S_TICK) |-> valid_bits[ram_waddr])
    else $error("tick walk wrote an unused slot");

endmodule

// File: hdl/periodic_task_tick_scheduler_top.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top
// Time-triggered cooperative scheduler: task slot table, tick and dispatch.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall) carries one item: create a slot,
//   timer tick, or dispatch. Result channel (rsp_valid / rsp_stall) returns
//   result items; the last item caused by a request has last set.
//   Slot period and counter live in a small RAM (one read, one write port,
//   registered read). Valid and ready flags are flip-flops.
// Request port stall (what holds the port after accepting an item):
//   create   : until the result is loaded into the output register.
//   tick     : the RAM read-modify-write walk goes one slot per cycle over
//              every slot, write-back trailing the read by one slot, then
//              leaves the walk.
//   dispatch : the in-order scan up to the highest ready slot (at most
//              TASK_SLOTS slots), held further while the receiver stalls.
//   Unknown request codes are dropped in the accepting cycle.
// The output register lets the next request be accepted while a result still
// waits; a stalled receiver only holds the sequencer when another result has
// to be pushed.
// Reset (rst, synchronous) clears all slot valid and ready flags and the
// control state; the table RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_top #(
  parameter int TASK_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [3:0]  task_slot,
  input  logic [15:0] initial_delay,
  input  logic [15:0] period,
  input  logic        has_task,
  // result channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  result_kind,
  output logic        error_flag,
  output logic [2:0]  task_index,
  output logic        last
);
  import pts_pkg::*;

  localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  logic              rsp_free;
  logic              push;
  rsp_t              push_data;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  slot_entry_t       ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  slot_entry_t       ram_rdata;

  // sequencer: flags, tick walk, dispatch scan
  pts_seq #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req_type      (req_type),
    .task_slot     (task_slot),
    .initial_delay (initial_delay),
    .period        (period),
    .has_task      (has_task),
    .rsp_free      (rsp_free),
    .push          (push),
    .push_data     (push_data),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  // slot table: period and counter per slot
  pts_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (TASK_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result register toward the receiver
  pts_rsp u_rsp (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_data   (push_data),
    .free        (rsp_free),
    .rsp_stall   (rsp_stall),
    .rsp_valid   (rsp_valid),
    .result_kind (result_kind),
    .error_flag  (error_flag),
    .task_index  (task_index),
    .last        (last)
  );

endmodule

// File: tb/periodic_task_tick_scheduler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_checker
// Tracks the slot table from accepted requests and checks every result item.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_checker #(
  parameter int TASK_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [3:0]  task_slot,
  input  logic [15:0] initial_delay,
  input  logic [15:0] period,
  input  logic        has_task,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  logic [1:0]  result_kind,
  input  logic        error_flag,
  input  logic [2:0]  task_index,
  input  logic        last,
  output int          fail_count,
  output int          pending
);
  import pts_pkg::*;

  localparam int MAX_REPORTS = 10;

  // shadow slot table
  logic        slot_valid  [TASK_SLOTS];
  logic        slot_ready  [TASK_SLOTS];
  logic [15:0] slot_period [TASK_SLOTS];
  logic [15:0] slot_count  [TASK_SLOTS];

  // results owed to the receiver, oldest first
  rsp_t sched_results_q [$];

  function automatic rsp_t make_result(logic [1:0] kind, logic err, logic [2:0] idx,
                                       logic fin);
    rsp_t r;
    r.kind = kind;
    r.err  = err;
    r.idx  = idx;
    r.last = fin;
    return r;
  endfunction

  task automatic run_scheduler_request(input logic [1:0] kind, input logic [3:0] slot,
                                       input logic [15:0] dly, input logic [15:0] per,
                                       input logic has);
    int   i;
    int   n;
    rsp_t r;
    case (kind)
      REQ_CREATE: begin
        if (int'(slot) < TASK_SLOTS && has) begin
          slot_period[slot] = per;
          slot_count[slot]  = dly;
          slot_ready[slot]  = 1'b0;
          slot_valid[slot]  = 1'b1;
          sched_results_q.push_back(make_result(KIND_CREATE, 1'b0, 3'd0, 1'b1));
        end else begin
          sched_results_q.push_back(make_result(KIND_CREATE, 1'b1, 3'd0, 1'b1));
        end
      end
      REQ_TICK: begin
        for (i = 0; i < TASK_SLOTS; i++) begin
          if (slot_valid[i]) begin
            if (slot_count[i] == 16'd0) begin
              slot_ready[i] = 1'b1;
              slot_count[i] = slot_period[i];
            end else begin
              slot_count[i] = slot_count[i] - 16'd1;
            end
          end
        end
      end
      REQ_DISPATCH: begin
        n = 0;
        for (i = 0; i < TASK_SLOTS; i++) begin
          if (slot_valid[i] && slot_ready[i]) begin
            slot_ready[i] = 1'b0;
            sched_results_q.push_back(make_result(KIND_TASK, 1'b0, 3'(i), 1'b0));
            n++;
          end
        end
        if (n == 0) begin
          sched_results_q.push_back(make_result(KIND_NONE, 1'b0, 3'd0, 1'b1));
        end else begin
          // mark the highest-index ready slot as the final one
          r = sched_results_q.pop_back();
          r.last = 1'b1;
          sched_results_q.push_back(r);
        end
      end
      default: begin
        // unknown code: dropped
      end
    endcase
  endtask

  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_valid[i] = 1'b0;
        slot_ready[i] = 1'b0;
      end
      sched_results_q.delete();
      fail_count = 0;
    end else begin
      // results leave before new expectations arrive in the same cycle
      if (rsp_valid && !rsp_stall) begin
        got = make_result(result_kind, error_flag, task_index, last);
        if (sched_results_q.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t ERROR: unexpected result kind=%0d err=%0d idx=%0d last=%0d",
                     $realtime, got.kind, got.err, got.idx, got.last);
          fail_count++;
        end else begin
          want = sched_results_q.pop_front();
          if (got.kind !== want.kind || got.err !== want.err ||
              got.idx !== want.idx || got.last !== want.last) begin
            if (fail_count < MAX_REPORTS)
              $display("%0t ERROR: result mismatch exp kind=%0d err=%0d idx=%0d last=%0d, %s",
                       $realtime, want.kind, want.err, want.idx, want.last,
                       $sformatf("got kind=%0d err=%0d idx=%0d last=%0d",
                                 got.kind, got.err, got.idx, got.last));
            fail_count++;
          end
        end
      end
      if (req_valid && !req_stall)
        run_scheduler_request(req_type, task_slot, initial_delay, period, has_task);
    end
    pending = sched_results_q.size();
  end

endmodule

// File: tb/periodic_task_tick_scheduler_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_top_tb
// Drives create, tick and dispatch requests into the scheduler: a directed
// opener over the corner cases, then random traffic in three idle/stall
// phases. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler_top_tb;
  import pts_pkg::*;

  localparam int TASK_SLOTS     = 8;
  localparam int ITEM_TARGET    = 370;
  // longest quiet stretch: a tick walk or a dispatch held by a stalled receiver
  localparam int WATCHDOG_LIMIT = 4000;
  // a tick walk after the last result still keeps the block busy
  localparam int TAIL_CYCLES    = 2 * TASK_SLOTS + 8;

  // code the block drops without a result
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        req_valid     = 1'b0;
  logic        req_stall;
  logic [1:0]  req_type      = REQ_CREATE;
  logic [3:0]  task_slot     = 4'd0;
  logic [15:0] initial_delay = 16'd0;
  logic [15:0] period        = 16'd0;
  logic        has_task      = 1'b0;
  logic        rsp_valid;
  logic        rsp_stall     = 1'b0;
  logic [1:0]  result_kind;
  logic        error_flag;
  logic [2:0]  task_index;
  logic        last;

  int send_idle_pct = 0;   // chance of a gap before each request
  int rcv_idle_pct  = 0;   // chance of stalling the result channel per cycle
  int items_sent    = 0;   // accepted requests, dropped codes excluded
  int quiet_cycles  = 0;
  int fail_count;
  int pending;

  always #1 clk = ~clk;

  periodic_task_tick_scheduler_top #(
    .TASK_SLOTS(TASK_SLOTS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .task_slot    (task_slot),
    .initial_delay(initial_delay),
    .period       (period),
    .has_task     (has_task),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result_kind  (result_kind),
    .error_flag   (error_flag),
    .task_index   (task_index),
    .last         (last)
  );

  periodic_task_tick_scheduler_checker #(
    .TASK_SLOTS(TASK_SLOTS)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req_type     (req_type),
    .task_slot    (task_slot),
    .initial_delay(initial_delay),
    .period       (period),
    .has_task     (has_task),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .result_kind  (result_kind),
    .error_flag   (error_flag),
    .task_index   (task_index),
    .last         (last),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // One request: optional gap with valid low, then hold until accepted.
  // Stall is looked at on the falling edge, where it is settled.
  task automatic send_request(input logic [1:0] kind, input logic [3:0] slot,
                              input logic [15:0] dly, input logic [15:0] per,
                              input logic has);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid     <= 1'b1;
    req_type      <= kind;
    task_slot     <= slot;
    initial_delay <= dly;
    period        <= per;
    has_task      <= has;
    @(negedge clk);
    while (req_stall) @(negedge clk);
    @(posedge clk);
    if (kind != REQ_UNKNOWN) items_sent++;
  endtask

  initial begin
    int phase;
    int phase_end;
    int pick;
    int i;

    send_idle_pct = 37;
    rcv_idle_pct  = 68;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed opener ---
    // dispatch straight after reset: nothing ready
    send_request(REQ_DISPATCH, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    // zero delay and zero period: fires on every tick
    send_request(REQ_CREATE, 4'd0, 16'h0000, 16'h0000, 1'b1);
    // all-ones delay and period on the top slot
    send_request(REQ_CREATE, 4'(TASK_SLOTS - 1), 16'hFFFF, 16'hFFFF, 1'b1);
    // slot past the table, both just past and at the field maximum
    send_request(REQ_CREATE, 4'(TASK_SLOTS), 16'($urandom), 16'($urandom), 1'b1);
    send_request(REQ_CREATE, 4'd15, 16'($urandom), 16'($urandom), 1'b1);
    // no task given
    send_request(REQ_CREATE, 4'd3, 16'($urandom), 16'($urandom), 1'b0);
    // unknown code is dropped
    send_request(REQ_UNKNOWN, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    send_request(REQ_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    send_request(REQ_DISPATCH, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    send_request(REQ_CREATE, 4'd3, 16'd1, 16'd2, 1'b1);
    send_request(REQ_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    send_request(REQ_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    // two ready slots, ascending order
    send_request(REQ_DISPATCH, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    send_request(REQ_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    // re-create of a ready slot drops its ready flag
    send_request(REQ_CREATE, 4'd0, 16'd5, 16'd5, 1'b1);
    send_request(REQ_DISPATCH, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    // every slot fires on the same tick: full eight-result dispatch
    for (i = 0; i < TASK_SLOTS; i++)
      send_request(REQ_CREATE, 4'(i), 16'd0, 16'd0, 1'b1);
    send_request(REQ_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    send_request(REQ_DISPATCH, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    send_request(REQ_DISPATCH, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));

    // --- random traffic in three idle phases ---
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 37;
          rcv_idle_pct  = 68;
        end
        1: begin
          send_idle_pct = 68;
          rcv_idle_pct  = 37;
        end
        default: begin
          send_idle_pct = 0;
          rcv_idle_pct  = 0;
        end
      endcase
      phase_end = ITEM_TARGET * (phase + 1) / 3;
      while (items_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 22) begin
          // mostly short periods on real slots so tasks keep firing;
          // the rest walks the full field ranges and the reject paths
          if ($urandom_range(3) != 0)
            send_request(REQ_CREATE, 4'($urandom_range(TASK_SLOTS - 1)),
                         16'($urandom_range(6)), 16'($urandom_range(6)), 1'b1);
          else
            send_request(REQ_CREATE, 4'($urandom), 16'($urandom), 16'($urandom),
                         1'($urandom));
        end else if (pick < 70) begin
          send_request(REQ_TICK, 4'($urandom), 16'($urandom), 16'($urandom),
                       1'($urandom));
        end else if (pick < 95) begin
          send_request(REQ_DISPATCH, 4'($urandom), 16'($urandom), 16'($urandom),
                       1'($urandom));
        end else begin
          send_request(REQ_UNKNOWN, 4'($urandom), 16'($urandom), 16'($urandom),
                       1'($urandom));
        end
      end
    end
    req_valid <= 1'b0;

    // drain, then give a trailing tick walk time to show stray results
    do @(negedge clk); while (pending != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
